// File: rtl/l1ms_pkg.sv
package l1ms_pkg;

	localparam int MAX_SHAPES = 64;
	localparam int MAX_COORDS = 1024;

	localparam int SHP_W = $clog2(MAX_SHAPES);
	localparam int CRD_W = $clog2(MAX_COORDS);
	localparam int NS_CFG_W = 7;
	localparam int NC_CFG_W = 11;
	localparam int CFG_W = 11;
	localparam int VAL_W = 32;
	localparam int OUT_SUM_W = 48;
	localparam int RAW_SUM_W = VAL_W + SHP_W + CRD_W;
	localparam int ACC_W = (RAW_SUM_W > OUT_SUM_W) ? RAW_SUM_W : OUT_SUM_W + 1;
	localparam int COORD_DEPTH = MAX_SHAPES * MAX_COORDS;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_GROUP = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic {
		REG_NUM_SHAPES = 1'b0,
		REG_NUM_COORDS = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PREP,
		ST_WALK,
		ST_FLUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             row_end;
		logic [SHP_W-1:0] shape;
	} walk_ctrl_t;

	function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] ao;
		logic [VAL_W-1:0] bo;
		ao = a ^ {1'b1, {(VAL_W-1){1'b0}}};
		bo = b ^ {1'b1, {(VAL_W-1){1'b0}}};
		return (ao > bo) ? (ao - bo) : (bo - ao);
	endfunction

endpackage

// File: rtl/l1_medoid_select.sv
// A query keeps busy high through its group scan and, if the group has members, its
// walk; done marks the result in the last busy cycle.
// The walk steps past each non-member shape before the last member, and each member
// row steps past non-members and over each coordinate of every member.
// Loads and group writes are taken one per cycle while idle; the receiver cannot stall.
// Reset clears control state, sets num_shapes 64, num_coords 1024; keeps coords and labels.
module l1_medoid_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        kind,
	input  logic [5:0]                        shape_index,
	input  logic [9:0]                        coord_index,
	input  logic signed [31:0]                coord_value,
	input  logic [7:0]                        group_id,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [l1ms_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                              done,
	output logic                              found,
	output logic [5:0]                        medoid_shape,
	output logic [5:0]                        medoid_rank,
	output logic [47:0]                       min_distance_sum
);

	localparam int SHP_W = l1ms_pkg::SHP_W;
	localparam int CRD_W = l1ms_pkg::CRD_W;
	localparam int VAL_W = l1ms_pkg::VAL_W;
	localparam int ACC_W = l1ms_pkg::ACC_W;
	localparam int OUT_SUM_W = l1ms_pkg::OUT_SUM_W;
	localparam int NS_W = l1ms_pkg::NS_CFG_W;
	localparam int NC_W = l1ms_pkg::NC_CFG_W;

	l1ms_pkg::state_t state_q, state_d;

	logic [NS_W-1:0] num_shapes_q;
	logic [NC_W-1:0] num_coords_q;

	logic [VAL_W-1:0] coord_mem [0:l1ms_pkg::COORD_DEPTH-1];
	logic [7:0]       group_mem [0:l1ms_pkg::MAX_SHAPES-1];

	logic [VAL_W-1:0] rd_a_s1, rd_b_s1;
	logic [7:0]       grp_rd_s1;
	logic             gv_s1;
	logic [SHP_W-1:0] gk_s1;

	logic [7:0]            grp_q;
	logic [NS_W-1:0]       k_q;
	logic [l1ms_pkg::MAX_SHAPES-1:0] mask_q;
	logic                  any_q;
	logic [SHP_W-1:0]      last_q;
	logic [SHP_W-1:0]      i_q, j_q;
	logic [CRD_W-1:0]      c_q;

	l1ms_pkg::walk_ctrl_t  ctrl_s1, ctrl_s2;
	logic [VAL_W-1:0]      absd_s2;

	logic [ACC_W-1:0]      acc_q, best_q, sum_next;
	logic                  have_q;
	logic [SHP_W-1:0]      best_shape_q, best_rank_q, rank_q;

	logic                  accept, is_load, is_group, is_query;
	logic [NS_W-1:0]       ns_eff;
	logic [NC_W-1:0]       nc_eff;
	logic [CRD_W-1:0]      last_c;
	logic                  zero_nc;
	logic                  scan_issue, mi, mj, issue;
	logic                  i_last, j_last, c_last;

	assign accept   = start && (state_q == l1ms_pkg::ST_IDLE);
	assign is_load  = accept && (kind == l1ms_pkg::KIND_LOAD);
	assign is_group = accept && (kind == l1ms_pkg::KIND_GROUP);
	assign is_query = accept && (kind == l1ms_pkg::KIND_QUERY);

	assign ns_eff  = (num_shapes_q > NS_W'(l1ms_pkg::MAX_SHAPES)) ?
		NS_W'(l1ms_pkg::MAX_SHAPES) : num_shapes_q;
	assign nc_eff  = (num_coords_q > NC_W'(l1ms_pkg::MAX_COORDS)) ?
		NC_W'(l1ms_pkg::MAX_COORDS) : num_coords_q;
	assign zero_nc = (nc_eff == '0);
	assign last_c  = zero_nc ? '0 : CRD_W'(nc_eff - NC_W'(1));

	assign scan_issue = (state_q == l1ms_pkg::ST_SCAN) && (k_q != ns_eff);
	assign mi     = mask_q[i_q];
	assign mj     = mask_q[j_q];
	assign issue  = (state_q == l1ms_pkg::ST_WALK) && mi && mj;
	assign i_last = (i_q == last_q);
	assign j_last = (j_q == last_q);
	assign c_last = (c_q == last_c);

	assign sum_next = acc_q + ACC_W'(absd_s2);

	always_ff @(posedge clk) begin
		if (is_load) begin
			coord_mem[{shape_index, coord_index}] <= coord_value;
		end
		rd_a_s1 <= coord_mem[{i_q, c_q}];
		rd_b_s1 <= coord_mem[{j_q, c_q}];
	end

	always_ff @(posedge clk) begin
		if (is_group) begin
			group_mem[shape_index] <= group_id;
		end
		grp_rd_s1 <= group_mem[k_q[SHP_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_shapes_q <= NS_W'(64);
			num_coords_q <= NC_W'(1024);
		end else if (cfg_we) begin
			unique case (l1ms_pkg::reg_index_t'(cfg_index))
				l1ms_pkg::REG_NUM_SHAPES: num_shapes_q <= cfg_wdata[NS_W-1:0];
				l1ms_pkg::REG_NUM_COORDS: num_coords_q <= cfg_wdata[NC_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= l1ms_pkg::ST_IDLE;
			grp_q        <= '0;
			k_q          <= '0;
			gv_s1        <= 1'b0;
			gk_s1        <= '0;
			mask_q       <= '0;
			any_q        <= 1'b0;
			last_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			c_q          <= '0;
			ctrl_s1      <= '0;
			ctrl_s2      <= '0;
			absd_s2      <= '0;
			acc_q        <= '0;
			best_q       <= '0;
			have_q       <= 1'b0;
			best_shape_q <= '0;
			best_rank_q  <= '0;
			rank_q       <= '0;
		end else begin
			state_q <= state_d;

			if (is_query) begin
				grp_q   <= group_id;
				k_q     <= '0;
				mask_q  <= '0;
				any_q   <= 1'b0;
				last_q  <= '0;
				i_q     <= '0;
				j_q     <= '0;
				c_q     <= '0;
				acc_q   <= '0;
				best_q  <= '0;
				have_q  <= 1'b0;
				rank_q  <= '0;
				best_shape_q <= '0;
				best_rank_q  <= '0;
			end

			gv_s1 <= scan_issue;
			gk_s1 <= k_q[SHP_W-1:0];
			if (scan_issue) begin
				k_q <= k_q + NS_W'(1);
			end
			if (gv_s1) begin
				mask_q[gk_s1] <= (grp_rd_s1 == grp_q);
				if (grp_rd_s1 == grp_q) begin
					any_q  <= 1'b1;
					last_q <= gk_s1;
				end
			end

			if (state_q == l1ms_pkg::ST_WALK) begin
				if (!mi) begin
					i_q <= i_q + SHP_W'(1);
				end else if (!mj) begin
					j_q <= j_q + SHP_W'(1);
				end else if (!c_last) begin
					c_q <= c_q + CRD_W'(1);
				end else begin
					c_q <= '0;
					if (!j_last) begin
						j_q <= j_q + SHP_W'(1);
					end else begin
						j_q <= '0;
						if (!i_last) begin
							i_q <= i_q + SHP_W'(1);
						end
					end
				end
			end

			ctrl_s1.valid   <= issue;
			ctrl_s1.row_end <= j_last && c_last;
			ctrl_s1.shape   <= i_q;

			ctrl_s2 <= ctrl_s1;
			absd_s2 <= zero_nc ? '0 : l1ms_pkg::abs_diff(rd_a_s1, rd_b_s1);

			if (ctrl_s2.valid) begin
				if (ctrl_s2.row_end) begin
					acc_q  <= '0;
					rank_q <= rank_q + SHP_W'(1);
					if (!have_q || (sum_next < best_q)) begin
						have_q       <= 1'b1;
						best_q       <= sum_next;
						best_shape_q <= ctrl_s2.shape;
						best_rank_q  <= rank_q;
					end
				end else begin
					acc_q <= sum_next;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			l1ms_pkg::ST_IDLE: begin
				if (is_query) begin
					state_d = l1ms_pkg::ST_SCAN;
				end
			end
			l1ms_pkg::ST_SCAN: begin
				if (k_q == ns_eff) begin
					state_d = l1ms_pkg::ST_DRAIN;
				end
			end
			l1ms_pkg::ST_DRAIN: state_d = l1ms_pkg::ST_PREP;
			l1ms_pkg::ST_PREP: begin
				state_d = any_q ? l1ms_pkg::ST_WALK : l1ms_pkg::ST_DONE;
			end
			l1ms_pkg::ST_WALK: begin
				if (mi && mj && c_last && j_last && i_last) begin
					state_d = l1ms_pkg::ST_FLUSH;
				end
			end
			l1ms_pkg::ST_FLUSH: begin
				if (!ctrl_s1.valid && !ctrl_s2.valid) begin
					state_d = l1ms_pkg::ST_DONE;
				end
			end
			l1ms_pkg::ST_DONE: state_d = l1ms_pkg::ST_IDLE;
			default: state_d = l1ms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy             = (state_q != l1ms_pkg::ST_IDLE);
		done             = (state_q == l1ms_pkg::ST_DONE);
		found            = have_q;
		medoid_shape     = have_q ? best_shape_q : '0;
		medoid_rank      = have_q ? best_rank_q : '0;
		min_distance_sum = '0;
		if (have_q) begin
			if (best_q[ACC_W-1:OUT_SUM_W] != '0) begin
				min_distance_sum = '1;
			end else begin
				min_distance_sum = best_q[OUT_SUM_W-1:0];
			end
		end
	end

endmodule

// File: rtl/l1ms_checker.sv
module l1ms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        done,
	input logic        found,
	input logic [5:0]  medoid_shape,
	input logic [5:0]  medoid_rank,
	input logic [47:0] min_distance_sum
);

	// A query accepted while idle raises busy, and the block stays busy until its result has been shown.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == l1ms_pkg::KIND_QUERY) |=> busy)
		else $error("query accepted without raising busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("busy did not drop after a result");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> (medoid_shape == 6'd0) && (medoid_rank == 6'd0) &&
			(min_distance_sum == 48'd0))
		else $error("empty group result carries nonzero fields");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> medoid_rank <= medoid_shape)
		else $error("medoid rank exceeds its shape index");

endmodule

bind l1_medoid_select l1ms_checker u_l1ms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.kind             (kind),
	.done             (done),
	.found            (found),
	.medoid_shape     (medoid_shape),
	.medoid_rank      (medoid_rank),
	.min_distance_sum (min_distance_sum)
);
